FILE: sv/csc_pkg.sv
// Package for the CORDIC sine/cosine block: sizes, data and control types,
// quadrant codes and the arctangent table. Depends on nothing.
package csc_pkg;

  localparam int ITERATIONS = 20;
  localparam int ANGLE_BITS = 12;
  localparam int FINE_BITS  = 24;

  localparam int OUT_W      = 18;
  localparam int XY_W       = 20;
  localparam int Z_W        = FINE_BITS + 1;
  localparam int ITER_W     = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
  localparam int TABLE_LEN  = 24;
  localparam int TAB_W      = $clog2(TABLE_LEN);
  localparam int TABLE_FINE = 24;
  localparam int LATENCY    = ITERATIONS + 1;

  localparam int INV_GAIN   = 39797;
  localparam int FIXED_ONE  = 65536;

  localparam int FINE_SHIFT_L = (FINE_BITS >= TABLE_FINE) ? FINE_BITS - TABLE_FINE : 0;
  localparam int FINE_SHIFT_R = (FINE_BITS < TABLE_FINE) ? TABLE_FINE - FINE_BITS : 0;
  localparam int ROUND_ADD    = (1 << FINE_SHIFT_R) >> 1;

  // round(atan(2^-i) / (2*pi) * 2^24)
  localparam logic [23:0] ATAN_TABLE [TABLE_LEN] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718,   24'd20860,   24'd10430,  24'd5215,   24'd2608,   24'd1304,
    24'd652,     24'd326,     24'd163,    24'd81,     24'd41,     24'd20,
    24'd10,      24'd5,       24'd3,      24'd1,      24'd1,      24'd0
  };

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic  valid;
    logic  cardinal;
    quad_e quad;
  } ctl_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

  // Arctangent of 2^-i scaled to the fine angle unit.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_W-1:0] idx);
    logic [47:0] t;
    t = 48'(ATAN_TABLE[idx]);
    if (FINE_BITS >= TABLE_FINE) begin
      t = t << FINE_SHIFT_L;
    end else begin
      t = (t + 48'(ROUND_ADD)) >> FINE_SHIFT_R;
    end
    return Z_W'(t);
  endfunction

endpackage

FILE: sv/cordic_sine_cosine.sv
// Top level of the CORDIC sine/cosine block: seeds the rotation, chains the
// cells and ends in the quadrant fold. Depends on csc_pkg, csc_cell, csc_fold.
//
// Usage:
//   Command channel: drive angle_i (1/4096 turn per step) and raise start.
//   The word is taken at every rising edge where start is high and busy is
//   low. busy is always low: a new angle may be issued in every cycle.
//   Result channel: done_o is high for one cycle with sine_o and cosine_o,
//   both signed 2.16 fixed point. Each result word must be captured in that
//   cycle; the receiver cannot stall the block, and nothing is held back.
//   Throughput: one angle per cycle. Each angle passes through the chain
//   of rotation cells, one CORDIC iteration per cell, and then through the
//   registered quadrant fold.
//   Results leave in the order the angles were taken.
//   Reset: rst_ni low clears the valid bits of every stage at once, so words
//   in flight are dropped and done_o stays low until a new angle passes
//   through the whole chain.
module cordic_sine_cosine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [csc_pkg::ANGLE_BITS-1:0]      angle_i,
  output logic                                done_o,
  output logic signed [csc_pkg::OUT_W-1:0]    sine_o,
  output logic signed [csc_pkg::OUT_W-1:0]    cosine_o
);

  csc_pkg::ctl_t ctl [csc_pkg::ITERATIONS+1];
  csc_pkg::vec_t vec [csc_pkg::ITERATIONS+1];

  logic [csc_pkg::ANGLE_BITS-3:0] inq;

  // The pipeline never refuses a word.
  assign busy = 1'b0;

  assign inq = angle_i[csc_pkg::ANGLE_BITS-3:0];

  // Seed of the first cell: gain-compensated start vector and the in-quadrant
  // angle moved into fine units. The cardinal flag rides along so the fold
  // can put out the exact pair instead of the CORDIC residual.
  always_comb begin
    ctl[0].valid    = start & ~busy;
    ctl[0].cardinal = (inq == '0);
    ctl[0].quad     = csc_pkg::quad_e'(angle_i[csc_pkg::ANGLE_BITS-1 -: 2]);
    vec[0].x        = csc_pkg::XY_W'(csc_pkg::INV_GAIN);
    vec[0].y        = '0;
    vec[0].z        = csc_pkg::Z_W'(inq) << (csc_pkg::FINE_BITS - csc_pkg::ANGLE_BITS);
  end

  // One cell per iteration; each hands its vector to the next in every cycle.
  for (genvar gi = 0; gi < csc_pkg::ITERATIONS; gi++) begin : g_cell
    csc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .iter_i (csc_pkg::ITER_W'(gi)),
      .ctl_i  (ctl[gi]),
      .vec_i  (vec[gi]),
      .ctl_o  (ctl[gi+1]),
      .vec_o  (vec[gi+1])
    );
  end

  csc_fold u_fold (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl[csc_pkg::ITERATIONS]),
    .vec_i    (vec[csc_pkg::ITERATIONS]),
    .done_o   (done_o),
    .sine_o   (sine_o),
    .cosine_o (cosine_o)
  );

endmodule

FILE: sv/csc_cell.sv
// One CORDIC rotation cell: a single iteration followed by its pipeline register.
// Depends on csc_pkg.
module csc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [csc_pkg::ITER_W-1:0] iter_i,
  input  csc_pkg::ctl_t              ctl_i,
  input  csc_pkg::vec_t              vec_i,
  output csc_pkg::ctl_t              ctl_o,
  output csc_pkg::vec_t              vec_o
);

  logic signed [csc_pkg::XY_W-1:0] xs;
  logic signed [csc_pkg::XY_W-1:0] ys;
  logic signed [csc_pkg::Z_W-1:0]  step;
  csc_pkg::ctl_t                   ctl_q;
  csc_pkg::vec_t                   vec_d;
  csc_pkg::vec_t                   vec_q;

  // The shift amount is fixed per cell, so each shifter reduces to wiring.
  always_comb begin
    xs   = vec_i.x >>> iter_i;
    ys   = vec_i.y >>> iter_i;
    step = csc_pkg::atan_entry(csc_pkg::TAB_W'(iter_i));
    if (!vec_i.z[csc_pkg::Z_W-1]) begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - step;
    end else begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign ctl_o = ctl_q;
  assign vec_o = vec_q;

endmodule

FILE: sv/csc_fold.sv
// Output stage: substitutes the exact cardinal pair, folds by quadrant and
// registers the result word. Depends on csc_pkg.
module csc_fold (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  csc_pkg::ctl_t                      ctl_i,
  input  csc_pkg::vec_t                      vec_i,
  output logic                               done_o,
  output logic signed [csc_pkg::OUT_W-1:0]   sine_o,
  output logic signed [csc_pkg::OUT_W-1:0]   cosine_o
);

  logic signed [csc_pkg::XY_W-1:0]  c;
  logic signed [csc_pkg::XY_W-1:0]  s;
  logic signed [csc_pkg::XY_W-1:0]  sn;
  logic signed [csc_pkg::XY_W-1:0]  cs;
  logic                             done_q;
  logic signed [csc_pkg::OUT_W-1:0] sine_q;
  logic signed [csc_pkg::OUT_W-1:0] cosine_q;

  always_comb begin
    if (ctl_i.cardinal) begin
      c = csc_pkg::XY_W'(csc_pkg::FIXED_ONE);
      s = '0;
    end else begin
      c = vec_i.x;
      s = vec_i.y;
    end
    unique case (ctl_i.quad)
      csc_pkg::QUAD_0: begin
        cs = c;
        sn = s;
      end
      csc_pkg::QUAD_1: begin
        cs = -s;
        sn = c;
      end
      csc_pkg::QUAD_2: begin
        cs = -c;
        sn = -s;
      end
      csc_pkg::QUAD_3: begin
        cs = s;
        sn = -c;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sine_q   <= sn[csc_pkg::OUT_W-1:0];
    cosine_q <= cs[csc_pkg::OUT_W-1:0];
  end

  assign done_o   = done_q;
  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

endmodule

FILE: sv/csc_checker.sv
// Port-level checker for the CORDIC sine/cosine block and its bind.
// Depends on csc_pkg and cordic_sine_cosine.
module csc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [csc_pkg::ANGLE_BITS-1:0]    angle_i,
  input logic                              done_o,
  input logic signed [csc_pkg::OUT_W-1:0]  sine_o,
  input logic signed [csc_pkg::OUT_W-1:0]  cosine_o
);

  // The block never holds off a command.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Every accepted word produces a result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(csc_pkg::LATENCY) done_o)
    else $error("result missing after latency");

  // A result only appears for a word accepted at the matching edge.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, csc_pkg::LATENCY))
    else $error("result without a command");

  // Angle zero gives the exact pair.
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && angle_i == '0) |-> ##(csc_pkg::LATENCY)
      (cosine_o == csc_pkg::OUT_W'(csc_pkg::FIXED_ONE) && sine_o == '0))
    else $error("angle zero not exact");

  // Results stay within the unit circle plus CORDIC error.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sine_o >= -18'sd65600 && sine_o <= 18'sd65600 &&
                cosine_o >= -18'sd65600 && cosine_o <= 18'sd65600))
    else $error("result out of range");

endmodule

bind cordic_sine_cosine csc_checker u_csc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .angle_i  (angle_i),
  .done_o   (done_o),
  .sine_o   (sine_o),
  .cosine_o (cosine_o)
);

FILE: tb/sv/cordic_sine_cosine_test.sv
// Self-checking testbench for the CORDIC sine/cosine block cordic_sine_cosine.
// It predicts each sine/cosine pair and compares it with the block's output.
// Depends on csc_pkg and the block's RTL.
module cordic_sine_cosine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csc_pkg::*;

  // One expected result word, kept with the angle that caused it so that a
  // mismatch report can name its source.
  typedef struct {
    logic [ANGLE_BITS-1:0]   angle;
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } sincos_t;

  logic                    clk_i;
  logic                    rst_ni  = 1'b0;
  logic                    start   = 1'b0;
  logic [ANGLE_BITS-1:0]   angle_i = '0;
  logic                    busy;
  logic                    done_o;
  logic signed [OUT_W-1:0] sine_o;
  logic signed [OUT_W-1:0] cosine_o;

  // Angles waiting to be issued, and the pairs that the block still owes us.
  logic [ANGLE_BITS-1:0] angle_queue[$];
  sincos_t               expected_sincos[$];

  int angles_taken   = 0;
  int total_angles   = 0;
  int mismatch_count = 0;
  int fail_count     = 0;

  // Idle control for the command side.
  int gap_left       = 0;
  int no_gap_run     = 0;
  int roll;

  cordic_sine_cosine u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .angle_i  (angle_i),
    .done_o   (done_o),
    .sine_o   (sine_o),
    .cosine_o (cosine_o)
  );

  // Computes the pair that the block should give for one angle. The top two
  // bits pick the quadrant. A zero in-quadrant angle takes the exact unit
  // vector; anything else runs the CORDIC rotation from the gain-compensated
  // start point. All arithmetic is done in 64 bits and only the low output
  // bits are kept, just as the output ports would hold them.
  function automatic sincos_t rotate_angle(input logic [ANGLE_BITS-1:0] angle);
    sincos_t               r;
    quad_e                 quad;
    logic [ANGLE_BITS-3:0] inq;
    longint                x, y, z, xs, ys, step, c, s, cs, sn;
    quad = quad_e'(angle[ANGLE_BITS-1 -: 2]);
    inq  = angle[ANGLE_BITS-3:0];
    if (inq == '0) begin
      c = FIXED_ONE;
      s = 0;
    end else begin
      x = INV_GAIN;
      y = 0;
      z = longint'(inq) <<< (FINE_BITS - ANGLE_BITS);
      for (int i = 0; i < ITERATIONS && i < TABLE_LEN; i++) begin
        // The >>> on a signed longint floors, like the block's shifters.
        xs = x >>> i;
        ys = y >>> i;
        // Rescale the table entry to the fine unit; one of the two shifts
        // is always zero.
        step = longint'(ATAN_TABLE[i]) <<< FINE_SHIFT_L;
        step = (step + ROUND_ADD) >>> FINE_SHIFT_R;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - step;
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + step;
        end
      end
      c = x;
      s = y;
    end
    // Fold the first-quadrant pair out to the real quadrant.
    case (quad)
      QUAD_0: begin
        cs = c;
        sn = s;
      end
      QUAD_1: begin
        cs = -s;
        sn = c;
      end
      QUAD_2: begin
        cs = -c;
        sn = -s;
      end
      default: begin
        cs = s;
        sn = -c;
      end
    endcase
    r.angle  = angle;
    r.sine   = sn[OUT_W-1:0];
    r.cosine = cs[OUT_W-1:0];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver. A command word counts as taken at an edge where start is high
  // and busy is low; the expectation is recorded at that same edge from the
  // angle that was on the port. After each word the driver may idle for a
  // random number of cycles: mostly none or a few, now and then a long
  // stretch, and sometimes a run of back-to-back words with no idling.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_sincos.push_back(rotate_angle(angle_i));
        angles_taken++;
      end
      if (start && busy) begin
        // The word was not taken; keep it on the port unchanged.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (angle_queue.size() > 0) begin
        start   <= 1'b1;
        angle_i <= angle_queue.pop_front();
        if (no_gap_run > 0) begin
          no_gap_run--;
          gap_left = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 5) begin
            no_gap_run = $urandom_range(20, 60);
            gap_left   = 0;
          end else if (roll < 60) begin
            gap_left = 0;
          end else if (roll < 92) begin
            gap_left = $urandom_range(1, 3);
          end else begin
            gap_left = $urandom_range(8, 40);
          end
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. done_o marks a result word for exactly one cycle, and the word
  // is captured at the edge that ends that cycle. Each word is checked
  // against the oldest pair still owed; a word with nothing owed is an error.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_sincos.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result word: sine=%0d cosine=%0d", sine_o, cosine_o);
        end
      end else begin
        sincos_t exp_pair;
        exp_pair = expected_sincos.pop_front();
        if (exp_pair.sine !== sine_o || exp_pair.cosine !== cosine_o) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("angle %0d: expected sine=%0d cosine=%0d, got sine=%0d cosine=%0d",
                     exp_pair.angle, exp_pair.sine, exp_pair.cosine, sine_o, cosine_o);
          end
        end
      end
    end
  end

  // Stimulus and end of the run.
  initial begin
    int directed[] = '{
      // Cardinal angles: the exact unit vector in every quadrant.
      0, 1024, 2048, 3072,
      // Next to the cardinal angles, where the rotation runs almost all one way.
      1, 1023, 1025, 2047, 2049, 3071, 3073, 4095,
      // Octant midpoints, where sine and cosine magnitudes meet.
      512, 1536, 2560, 3584,
      // Alternating bit patterns and a few odd points.
      1365, 2730, 341, 682, 170, 3925
    };
    foreach (directed[k]) begin
      angle_queue.push_back(directed[k]);
    end
    // Random angles, with cardinal angles mixed in more often than chance.
    for (int k = 0; k < 900; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        angle_queue.push_back(ANGLE_BITS'($urandom_range(0, 3)) << (ANGLE_BITS - 2));
      end else begin
        angle_queue.push_back(ANGLE_BITS'($urandom_range(0, (1 << ANGLE_BITS) - 1)));
      end
    end
    total_angles = angle_queue.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every word has been taken and every pair has come back,
    // then give the pipeline time to show any stray words.
    while (angles_taken < total_angles || expected_sincos.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("cordic_sine_cosine: match");
    end else begin
      $display("cordic_sine_cosine: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with every gap at its longest.
  initial begin
    #2ms;
    $display("cordic_sine_cosine: mismatch");
    $finish;
  end

endmodule

FILE: files.f
sv/csc_pkg.sv
sv/csc_cell.sv
sv/csc_fold.sv
sv/cordic_sine_cosine.sv
sv/csc_checker.sv
tb/sv/cordic_sine_cosine_test.sv
